[src/cjk_pkg.sv]
// ----------------------------------------------------------------------------
// cjk_pkg
// Shared types and constants of the CJK isolating UTF-8 encoder.
// ----------------------------------------------------------------------------
package cjk_pkg;

  localparam int unsigned CpW = 21;

  localparam logic [7:0]     SpaceByte  = 8'h20;
  localparam logic [CpW-1:0] CpMaximum  = 21'h10FFFF;

  // One classified request: UTF-8 bytes (enc[0] goes out first), byte count
  // (zero means the request emits nothing) and the space-wrap flag.
  typedef struct packed {
    logic [3:0][7:0] enc;
    logic [2:0]      len;
    logic            wrap;
  } cjk_desc_t;

endpackage

[src/cjk_front.sv]
// ----------------------------------------------------------------------------
// cjk_front
// Accepts code points, encodes them to UTF-8 and flags CJK characters.
// ----------------------------------------------------------------------------
module cjk_front (
  input  logic [cjk_pkg::CpW-1:0] code_point_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  output logic                    push_valid_o,
  output cjk_pkg::cjk_desc_t      push_desc_o,
  input  logic                    push_ready_i
);
  import cjk_pkg::*;

  localparam int unsigned NumRanges = 8;
  localparam int unsigned NumPoints = 31;

  localparam logic [NumRanges-1:0][CpW-1:0] RangeLo = {
    21'h2F800, 21'h0F900, 21'h2B820, 21'h2B740,
    21'h2A700, 21'h20000, 21'h03400, 21'h04E00
  };
  localparam logic [NumRanges-1:0][CpW-1:0] RangeHi = {
    21'h2FA1F, 21'h0FAFF, 21'h2CEAF, 21'h2B81F,
    21'h2B73F, 21'h2A6DF, 21'h04DBF, 21'h09FFF
  };
  localparam logic [NumPoints-1:0][CpW-1:0] Points = {
    21'h02019, 21'h02018, 21'h03009, 21'h03008, 21'h0300B, 21'h0300A,
    21'h0FF0E, 21'h02013, 21'h02026, 21'h02014, 21'h03011, 21'h03010,
    21'h03015, 21'h03014, 21'h0FF09, 21'h0FF08, 21'h0201D, 21'h0201C,
    21'h02019, 21'h02018, 21'h0300F, 21'h0300E, 21'h0300D, 21'h0300C,
    21'h0FF1A, 21'h0FF1B, 21'h03001, 21'h0FF0C, 21'h0FF01, 21'h0FF1F,
    21'h03002
  };

  logic [NumRanges-1:0] range_hit;
  logic [NumPoints-1:0] point_hit;
  cjk_desc_t            desc;

  always_comb begin
    for (int i = 0; i < NumRanges; i++) begin
      range_hit[i] = (code_point_i >= RangeLo[i]) && (code_point_i <= RangeHi[i]);
    end
    for (int i = 0; i < NumPoints; i++) begin
      point_hit[i] = (code_point_i == Points[i]);
    end
  end

  always_comb begin
    desc.enc  = '0;
    desc.len  = 3'd0;
    desc.wrap = (|range_hit) || (|point_hit);
    priority if (code_point_i == '0) begin
      desc.len = 3'd0;
    end else if (code_point_i <= 21'h7F) begin
      desc.len    = 3'd1;
      desc.enc[0] = code_point_i[7:0];
    end else if (code_point_i <= 21'h7FF) begin
      desc.len    = 3'd2;
      desc.enc[0] = {3'b110, code_point_i[10:6]};
      desc.enc[1] = {2'b10, code_point_i[5:0]};
    end else if (code_point_i >= 21'hD800 && code_point_i <= 21'hDFFF) begin
      desc.len = 3'd0;
    end else if (code_point_i <= 21'hFFFF) begin
      desc.len    = 3'd3;
      desc.enc[0] = {4'b1110, code_point_i[15:12]};
      desc.enc[1] = {2'b10, code_point_i[11:6]};
      desc.enc[2] = {2'b10, code_point_i[5:0]};
    end else if (code_point_i <= CpMaximum) begin
      desc.len    = 3'd4;
      desc.enc[0] = {5'b11110, code_point_i[20:18]};
      desc.enc[1] = {2'b10, code_point_i[17:12]};
      desc.enc[2] = {2'b10, code_point_i[11:6]};
      desc.enc[3] = {2'b10, code_point_i[5:0]};
    end else begin
      desc.len = 3'd0;
    end
  end

  // Requests that encode to nothing are consumed without a queue entry.
  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i && (desc.len != 3'd0);
  assign push_desc_o  = desc;

endmodule

[src/cjk_queue.sv]
// ----------------------------------------------------------------------------
// cjk_queue
// Small FIFO of classified requests between the front and back ends.
// ----------------------------------------------------------------------------
module cjk_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  input  cjk_pkg::cjk_desc_t push_desc_i,
  output logic               push_ready_o,
  output logic               pop_valid_o,
  output cjk_pkg::cjk_desc_t pop_desc_o,
  input  logic               pop_ready_i
);
  import cjk_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] Full    = CntW'(DEPTH);

  cjk_desc_t       mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign push_ready_o = (cnt_q != Full);
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_desc_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({push, pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_desc_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= Full)
    else $error("queue occupancy above depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("queue count missed a push");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push) |=> (cnt_q == $past(cnt_q) - 1'b1))
    else $error("queue count missed a pop");

endmodule

[src/cjk_back.sv]
// ----------------------------------------------------------------------------
// cjk_back
// Serializes each classified request into bytes, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module cjk_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               pop_valid_i,
  input  cjk_pkg::cjk_desc_t pop_desc_i,
  output logic               pop_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         out_byte_o,
  output logic               last_byte_o
);
  import cjk_pkg::*;

  cjk_desc_t  cur_q, cur_d;
  logic [2:0] idx_q, idx_d;
  logic       busy_q, busy_d;
  logic [2:0] total;
  logic [1:0] enc_idx;
  logic       last;
  logic       advance;

  assign total   = cur_q.len + (cur_q.wrap ? 3'd2 : 3'd0);
  assign last    = (idx_q == total - 3'd1);
  assign advance = busy_q && out_ready_i;
  assign enc_idx = cur_q.wrap ? 2'(idx_q - 3'd1) : idx_q[1:0];

  assign pop_ready_o = !busy_q || (out_ready_i && last);
  assign out_valid_o = busy_q;
  assign last_byte_o = last;

  always_comb begin
    if (cur_q.wrap && (idx_q == 3'd0 || last)) begin
      out_byte_o = SpaceByte;
    end else begin
      out_byte_o = cur_q.enc[enc_idx];
    end
  end

  always_comb begin
    cur_d  = cur_q;
    idx_d  = idx_q;
    busy_d = busy_q;
    if (pop_ready_o) begin
      busy_d = pop_valid_i;
      cur_d  = pop_desc_i;
      idx_d  = 3'd0;
    end else if (advance) begin
      idx_d = idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 3'd0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) busy_q |-> (idx_q < total))
    else $error("byte index ran past the sequence");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !out_ready_i) |=> (busy_q && $stable(idx_q)))
    else $error("stalled byte changed");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && cur_q.wrap && last) |-> (out_byte_o == SpaceByte))
    else $error("wrapped sequence must end in a space");

endmodule

[src/cjk_isolating_utf8_encoder.sv]
// ----------------------------------------------------------------------------
// cjk_isolating_utf8_encoder
// UTF-8 encoder that isolates CJK characters between space bytes.
// ----------------------------------------------------------------------------
// Input channel: one code point per request (code_point_i, valid/ready).
// Output channel: one byte per request (out_byte_o, last_byte_o), with
// last_byte_o set on the final byte of each code point.
// A code point gives 1 to 4 UTF-8 bytes; CJK ideographs and CJK punctuation
// get a space byte before and after, up to 6 bytes. Zero, surrogates and
// values above 0x10FFFF give no bytes and are simply consumed.
// The front end classifies and encodes in the accept cycle and writes a
// queue of QUEUE_DEPTH entries; the back end pops an entry into its
// serializer register and sends its bytes at one per cycle while the
// receiver is ready, so the first byte is offered once the entry has
// passed the queue and the serializer register. Throughput is set by the
// back-end serializer: one output byte per cycle while the receiver is
// ready, so sustained input is bounded by each code point's byte count.
// When the receiver stalls, the current byte holds and the queue fills;
// input ready drops once the queue is full.
// Reset empties the queue and idles the serializer; no clearing pass.
// ----------------------------------------------------------------------------
module cjk_isolating_utf8_encoder #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [cjk_pkg::CpW-1:0] code_point_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  output logic [7:0]              out_byte_o,
  output logic                    last_byte_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i
);
  import cjk_pkg::*;

  logic      push_valid, push_ready;
  cjk_desc_t push_desc;
  logic      pop_valid, pop_ready;
  cjk_desc_t pop_desc;

  cjk_front u_front (
    .code_point_i (code_point_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .push_valid_o (push_valid),
    .push_desc_o  (push_desc),
    .push_ready_i (push_ready)
  );

  cjk_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_desc_i  (push_desc),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_desc_o   (pop_desc),
    .pop_ready_i  (pop_ready)
  );

  cjk_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_desc_i  (pop_desc),
    .pop_ready_o (pop_ready),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .last_byte_o (last_byte_o)
  );

endmodule
